@@ src/envelope_wire_format_decoder_assert.svh @@
// Assertion macros shared by the decoder modules.
// Each expects i_clk and i_rst_n in the enclosing module.
`ifndef ENVELOPE_WIRE_FORMAT_DECODER_ASSERT_SVH
`define ENVELOPE_WIRE_FORMAT_DECODER_ASSERT_SVH

// Property checked at every clock edge out of reset
`define EWFD_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define EWFD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ewfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ewfd_pkg;

    // Length field width (bytes_remaining)
    localparam int LEN_BITS = 16;

    // Varint limits
    localparam int VARINT_MAX_BYTES = 10;
    localparam int VARINT_LAST_IDX  = VARINT_MAX_BYTES - 1;

    // Result queue sizing
    localparam int MAX_PUSH = 2;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    // Wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    // Field numbers with special handling
    localparam logic [3:0] FLD_NONE         = 4'd0;
    localparam logic [3:0] FLD_FIRST        = 4'd1;
    localparam logic [3:0] FLD_LAST         = 4'd8;
    localparam logic [3:0] FLD_U32_A        = 4'd1;
    localparam logic [3:0] FLD_U32_B        = 4'd2;
    localparam logic [3:0] FLD_U32_C        = 4'd3;
    localparam logic [3:0] FLD_U64          = 4'd4;
    localparam logic [3:0] FLD_U32_D        = 4'd5;
    localparam logic [3:0] FLD_PAYLOAD_TYPE = 4'd6;
    localparam logic [3:0] FLD_PAYLOAD      = 4'd7;
    localparam logic [3:0] FLD_U32_E        = 4'd8;

    typedef enum logic [4:0] {
        PH_KEY   = 5'b00001,
        PH_VALUE = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_ERROR = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        EV_SCALAR      = 2'd0,
        EV_BYTES_START = 2'd1,
        EV_BYTES_DATA  = 2'd2,
        EV_MSG_END     = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_MALFORMED   = 2'd2
    } t_status;

    typedef struct packed {
        t_event      kind;
        logic [3:0]  id;
        logic [63:0] value;
        logic [7:0]  data;
        t_status     status;
    } t_result;

    // Results produced by one item: item0 first, item1 only when num is 2
    typedef struct packed {
        logic [1:0] num;
        t_result    item0;
        t_result    item1;
    } t_push;

endpackage

`default_nettype wire

@@ src/ewfd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "envelope_wire_format_decoder_assert.svh"

module ewfd_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_no_byte,
    input  wire logic          i_msg_end,
    output ewfd_pkg::t_push    o_push
);
    import ewfd_pkg::*;

    t_phase                r_phase,  n_phase;
    logic [63:0]           r_accum,  n_accum;
    logic [3:0]            r_vcnt,   n_vcnt;
    logic [3:0]            r_field,  n_field;
    logic [LEN_BITS-1:0]   r_remain, n_remain;
    t_status               r_err,    n_err;

    logic [5:0]  take_sh;
    logic [63:0] take_accum;
    logic [3:0]  take_cnt;
    logic        take_cont;
    logic        take_over;
    logic [3:0]  key_field;
    logic [2:0]  key_wt;
    t_result     byte_res;
    logic        byte_emit;
    t_result     end_res;
    t_status     end_status;

    // Varint step: shift-or seven bits, tenth byte contributes only bit 63
    assign take_sh    = 6'(r_vcnt) * 6'd7;
    assign take_accum = (r_vcnt < 4'(VARINT_LAST_IDX))
                      ? (r_accum | (64'(i_in_byte[6:0]) << take_sh))
                      : (r_accum | {i_in_byte[0], 63'd0});
    assign take_cnt   = r_vcnt + 4'd1;
    assign take_cont  = i_in_byte[7];
    assign take_over  = take_cont && (take_cnt >= 4'(VARINT_MAX_BYTES));

    // Key split: out-of-range field numbers map to "unknown"
    assign key_wt    = take_accum[2:0];
    assign key_field = ((take_accum[63:7] == '0) && (take_accum[6:3] >= FLD_FIRST)
                        && (take_accum[6:3] <= FLD_LAST)) ? take_accum[6:3] : FLD_NONE;

    // Next state and byte result
    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_vcnt    = r_vcnt;
        n_field   = r_field;
        n_remain  = r_remain;
        n_err     = r_err;
        byte_emit = 1'b0;
        byte_res  = '{kind: EV_SCALAR, id: r_field, value: 64'd0, data: 8'd0,
                      status: ST_OK};

        if (!i_no_byte && r_phase != PH_ERROR) begin
            if (r_phase == PH_DATA) begin
                if (r_field inside {FLD_PAYLOAD_TYPE, FLD_PAYLOAD}) begin
                    byte_emit     = 1'b1;
                    byte_res.kind = EV_BYTES_DATA;
                    byte_res.data = i_in_byte;
                end
                n_remain = r_remain - 1'b1;
                if (n_remain == '0) begin
                    n_phase = PH_KEY;
                end
            end else if (take_over) begin
                n_err   = ST_MALFORMED;
                n_phase = PH_ERROR;
                n_accum = '0;
                n_vcnt  = '0;
            end else if (take_cont) begin
                n_accum = take_accum;
                n_vcnt  = take_cnt;
            end else begin
                n_accum = '0;
                n_vcnt  = '0;
                case (r_phase)
                    PH_KEY: begin
                        n_field = key_field;
                        if (key_wt == WT_VARINT) begin
                            n_phase = PH_VALUE;
                        end else if (key_wt == WT_LEN) begin
                            n_phase = PH_LEN;
                        end else begin
                            n_err   = ST_UNSUPPORTED;
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_VALUE: begin
                        if (r_field == FLD_U64) begin
                            byte_emit      = 1'b1;
                            byte_res.value = take_accum;
                        end else if (r_field inside {FLD_U32_A, FLD_U32_B, FLD_U32_C,
                                                     FLD_U32_D, FLD_U32_E}) begin
                            byte_emit      = 1'b1;
                            byte_res.value = {32'd0, take_accum[31:0]};
                        end
                        n_phase = PH_KEY;
                    end
                    PH_LEN: begin
                        if (take_accum[63:LEN_BITS] != '0) begin
                            n_err   = ST_MALFORMED;
                            n_phase = PH_ERROR;
                        end else begin
                            if (r_field inside {FLD_PAYLOAD_TYPE, FLD_PAYLOAD}) begin
                                byte_emit      = 1'b1;
                                byte_res.kind  = EV_BYTES_START;
                                byte_res.value = take_accum;
                            end
                            n_remain = take_accum[LEN_BITS-1:0];
                            n_phase  = (take_accum == '0) ? PH_KEY : PH_DATA;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // End-of-message status: cut off mid-field is malformed
    always_comb begin
        end_status = n_err;
        if (n_phase != PH_ERROR && (n_phase != PH_KEY || n_vcnt != '0)) begin
            end_status = ST_MALFORMED;
        end
        end_res = '{kind: EV_MSG_END, id: FLD_NONE, value: 64'd0, data: 8'd0,
                    status: end_status};
    end

    // Pack up to two results, end event last
    always_comb begin
        o_push.num   = 2'd0;
        o_push.item0 = byte_emit ? byte_res : end_res;
        o_push.item1 = end_res;
        if (i_accept) begin
            o_push.num = 2'(byte_emit) + 2'(i_msg_end);
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_msg_end)) begin
            r_phase  <= PH_KEY;
            r_accum  <= '0;
            r_vcnt   <= '0;
            r_field  <= FLD_NONE;
            r_remain <= '0;
            r_err    <= ST_OK;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_accum  <= n_accum;
            r_vcnt   <= n_vcnt;
            r_field  <= n_field;
            r_remain <= n_remain;
            r_err    <= n_err;
        end
    end

    `EWFD_CHECK(a_err_phase, (r_phase == PH_ERROR) == (r_err != ST_OK), "error code and phase disagree")
    `EWFD_CHECK(a_vcnt_max, r_vcnt < 4'(VARINT_MAX_BYTES), "varint byte count overran")
    `EWFD_CHECK(a_data_remain, (r_phase != PH_DATA) || (r_remain != '0), "data phase with no bytes left")

endmodule

`default_nettype wire

@@ src/ewfd_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "envelope_wire_format_decoder_assert.svh"

module ewfd_out_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ewfd_pkg::t_push i_push,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ewfd_pkg::t_result  o_item
);
    import ewfd_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count,  n_count;
    logic [Q_AW-1:0]   wr_ptr_1;
    logic              pop;

    // Handshake: hold off input unless room for a full pair
    assign o_stall  = r_count > Q_CW'(Q_DEPTH - MAX_PUSH);
    assign o_valid  = r_count != '0;
    assign o_item   = r_mem[r_rd_ptr];
    assign pop      = o_valid && !i_stall;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    // Pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_AW'(i_push.num);
        n_rd_ptr = r_rd_ptr + Q_AW'(pop);
        n_count  = r_count + Q_CW'(i_push.num) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.item1;
        end
    end

    `EWFD_CHECK(a_no_overfill, (i_push.num == 2'd0) || !o_stall, "push while queue lacks room")
    `EWFD_CHECK(a_push_max, i_push.num <= 2'(MAX_PUSH), "too many results in one push")
    `EWFD_CHECK_NEXT(a_count_track, 1'b1, !$past(i_rst_n) || (r_count == Q_CW'($past(r_count) + Q_CW'($past(i_push.num)) - Q_CW'($past(pop)))), "queue fill count drifted")

endmodule

`default_nettype wire

@@ src/envelope_wire_format_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_in_byte, i_no_byte, i_msg_end
// result    out        o_valid / i_stall  o_event_kind, o_field_id, o_field_value,
//                                         o_data_byte, o_status
//
// An item is parsed in the cycle it is accepted; its results are in the queue the next cycle, behind any earlier ones.
// One item per cycle while o_stall is low; an item that yields two results (a field event plus
// message end) puts both into the four-entry result queue, which hands them out one at a time.
// o_stall rises when the queue has fewer than two free entries.
// i_rst_n is synchronous, active low; parser state also returns to reset after each end item.

module envelope_wire_format_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_no_byte,
    input  wire logic         i_msg_end,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [1:0]        o_event_kind,
    output logic [3:0]        o_field_id,
    output logic [63:0]       o_field_value,
    output logic [7:0]        o_data_byte,
    output logic [1:0]        o_status
);
    import ewfd_pkg::*;

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = i_valid && !o_stall;

    // Byte parser
    ewfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_no_byte (i_no_byte),
        .i_msg_end (i_msg_end),
        .o_push    (push)
    );

    // Result queue
    ewfd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (head)
    );

    assign o_event_kind  = head.kind;
    assign o_field_id    = head.id;
    assign o_field_value = head.value;
    assign o_data_byte   = head.data;
    assign o_status      = head.status;

endmodule

`default_nettype wire
